// ===== design/bpa_pkg.sv =====
// Package for the buddy page allocator: default sizes, status codes, opcodes.
// No dependencies.
package bpa_pkg;
  localparam int unsigned PageBitsDef = 12;
  localparam int unsigned MemBitsDef  = 20;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadSize = 2'd1,
    StNoMem   = 2'd2,
    StBadFree = 2'd3
  } status_e;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;
endpackage

// ===== design/buddy_page_allocator.sv =====
// Top level of the buddy page allocator: sequencer plus free map and order store.
// Depends on bpa_pkg.
//
//  channel | direction | beat marker       | payload
//  request | in        | start_i & !busy_o | opcode_i, request_bytes_i, free_page_i
//  result  | out       | done_o            | status_o, granted_page_o, granted_order_o
//
// An allocate scans the free map from the needed order upward, lowest node first,
// reading and then testing each node, then splits one level per cycle. A bad size
// goes straight to the result. A free looks up the order (read, then check), reads
// and tests the buddy at each merge level in turn, then marks the merged block free.
// After reset a clearing pass sets up both memories; busy_o stays high meanwhile.
// The receiver cannot stall; done_o lasts one cycle.
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int unsigned PAGE_BITS = PageBitsDef,
  parameter int unsigned MEM_BITS  = MemBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        opcode_i,
  input  logic [20:0] request_bytes_i,
  input  logic [7:0]  free_page_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [7:0]  granted_page_o,
  output logic [3:0]  granted_order_o
);
  localparam int unsigned Top   = MEM_BITS - PAGE_BITS;
  localparam int unsigned NPg   = 1 << Top;
  localparam int unsigned NNd   = 2 * NPg;
  localparam int unsigned NdW   = Top + 1;
  localparam int unsigned KW    = $clog2(Top + 2);
  localparam logic [4:0]  NotAl = (Top < 15) ? 5'd15 : 5'd31;

  typedef enum logic [10:0] {
    SClr   = 11'b00000000001,
    SIdle  = 11'b00000000010,
    SSrchR = 11'b00000000100,
    SSrchC = 11'b00000001000,
    SSplit = 11'b00000010000,
    SOrdR  = 11'b00000100000,
    SOrdC  = 11'b00001000000,
    SBudR  = 11'b00010000000,
    SBudC  = 11'b00100000000,
    SMark  = 11'b01000000000,
    SDone  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // memories
  logic        fm_mem [NNd];
  logic [4:0]  bo_mem [NPg];
  logic          fm_we, fm_wd, fm_rd_q;
  logic [NdW-1:0] fm_wa, fm_ra;
  logic          bo_we;
  logic [4:0]    bo_wd, bo_rd_q;
  logic [Top-1:0] bo_wa, bo_ra;

  always_ff @(posedge clk_i) begin
    if (fm_we) fm_mem[fm_wa] <= fm_wd;
    fm_rd_q <= fm_mem[fm_ra];
    if (bo_we) bo_mem[bo_wa] <= bo_wd;
    bo_rd_q <= bo_mem[bo_ra];
  end

  logic [NdW:0]   clr_q, clr_d;
  logic [KW-1:0]  k_q, k_d, need_q, need_d, orig_q, orig_d;
  logic [Top:0]   idx_q, idx_d;   // index within level / page
  logic [Top-1:0] page_q, page_d;
  logic           op_q, op_d;
  logic [1:0]     st_q, st_d;

  function automatic logic [NdW-1:0] node_of(logic [Top-1:0] pg, logic [KW-1:0] k);
    logic [NdW-1:0] base;
    base = NdW'((1 << (Top - k)) - 1);
    return base + NdW'(pg >> k);
  endfunction

  function automatic logic [NdW-1:0] node_lvl(logic [Top:0] i, logic [KW-1:0] k);
    return NdW'((1 << (Top - k)) - 1) + NdW'(i);
  endfunction

  // needed order from byte count
  logic [KW-1:0] need_c;
  logic          bad_sz;
  always_comb begin
    need_c = '0;
    for (int n = Top; n >= 1; n--)
      if ((64'(1) << (PAGE_BITS + n - 1)) < 64'(request_bytes_i)) begin
        if (need_c == '0) need_c = KW'(n);
      end
    bad_sz = (request_bytes_i == '0) || (64'(request_bytes_i) > (64'(1) << MEM_BITS));
  end

  logic [Top-1:0] buddy;
  assign buddy = page_q ^ Top'(1 << k_q);

  always_comb begin
    state_d = state_q; clr_d = clr_q; k_d = k_q; need_d = need_q; orig_d = orig_q;
    idx_d = idx_q; page_d = page_q; op_d = op_q; st_d = st_q;
    fm_we = 1'b0; fm_wa = '0; fm_wd = 1'b0; fm_ra = '0;
    bo_we = 1'b0; bo_wa = '0; bo_wd = NotAl; bo_ra = page_q;
    unique case (state_q)
      SClr: begin
        fm_we = 1'b1; fm_wa = clr_q[NdW-1:0]; fm_wd = (clr_q == '0);
        bo_we = 1'b1; bo_wa = clr_q[Top-1:0]; bo_wd = NotAl;
        clr_d = clr_q + 1'b1;
        if (clr_q == (NdW+1)'(NNd - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (start_i) begin
          op_d = opcode_i;
          if (opcode_i == OpAlloc) begin
            need_d = need_c; k_d = need_c; idx_d = '0; page_d = '0; orig_d = '0;
            if (bad_sz) begin st_d = StBadSize; state_d = SDone; end
            else state_d = SSrchR;
          end else begin
            page_d = free_page_i[Top-1:0]; orig_d = '0;
            if (32'(free_page_i) >= NPg) begin st_d = StBadFree; page_d = '0;
              state_d = SDone; end
            else state_d = SOrdR;
          end
        end
      end
      SSrchR: begin
        fm_ra = node_lvl(idx_q, k_q);
        state_d = SSrchC;
      end
      SSrchC: begin
        if (fm_rd_q) begin
          page_d = Top'(idx_q << k_q);
          fm_we = 1'b1; fm_wa = node_lvl(idx_q, k_q); fm_wd = 1'b0;
          state_d = SSplit;
        end else if (32'(idx_q) + 1 < (1 << (Top - k_q))) begin
          idx_d = idx_q + 1'b1; state_d = SSrchR;
        end else if (k_q < KW'(Top)) begin
          k_d = k_q + 1'b1; idx_d = '0; state_d = SSrchR;
        end else begin
          st_d = StNoMem; page_d = '0; need_d = '0; state_d = SDone;
        end
      end
      SSplit: begin
        if (k_q > need_q) begin
          fm_we = 1'b1; fm_wd = 1'b1;
          fm_wa = node_of(page_q + Top'(1 << (k_q - 1'b1)), k_q - 1'b1);
          k_d = k_q - 1'b1;
        end else begin
          bo_we = 1'b1; bo_wa = page_q; bo_wd = 5'(need_q);
          st_d = StOk; orig_d = need_q; state_d = SDone;
        end
      end
      SOrdR: begin
        bo_ra = page_q; state_d = SOrdC;
      end
      SOrdC: begin
        if (bo_rd_q == NotAl || 32'(bo_rd_q) > Top) begin
          st_d = StBadFree; page_d = '0; state_d = SDone;
        end else begin
          k_d = KW'(bo_rd_q); orig_d = KW'(bo_rd_q);
          bo_we = 1'b1; bo_wa = page_q; bo_wd = NotAl;
          state_d = SBudR;
        end
      end
      SBudR: begin
        if (k_q < KW'(Top)) begin
          fm_ra = node_of(buddy, k_q); state_d = SBudC;
        end else state_d = SMark;
      end
      SBudC: begin
        if (fm_rd_q) begin
          fm_we = 1'b1; fm_wa = node_of(buddy, k_q); fm_wd = 1'b0;
          page_d = page_q & ~Top'(1 << k_q); k_d = k_q + 1'b1; state_d = SBudR;
        end else state_d = SMark;
      end
      SMark: begin
        fm_we = 1'b1; fm_wa = node_of(page_q, k_q); fm_wd = 1'b1;
        st_d = StOk; page_d = '0; state_d = SDone;
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr; clr_q <= '0; op_q <= 1'b0; st_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; op_q <= op_d; st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; need_q <= need_d; orig_q <= orig_d; idx_q <= idx_d; page_q <= page_d;
  end

  assign busy_o          = (state_q != SIdle);
  assign done_o          = (state_q == SDone);
  assign status_o        = st_q;
  assign granted_page_o  = (st_q == StOk && op_q == OpAlloc) ? 8'(page_q) : 8'd0;
  assign granted_order_o = (st_q == StOk) ? 4'(orig_q) : 4'd0;

  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != StOk) |-> (granted_page_o == 8'd0 && granted_order_o == 4'd0))
    else $error("error result with payload");
  a_free_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && op_q == OpFree) |-> granted_page_o == 8'd0) else $error("free gave page");
endmodule

// ===== test/buddy_page_allocator_tb.sv =====
// Self-checking testbench for the buddy page allocator: directed table, then random
// alloc/free traffic checked against a behavioural model of the page tree.
// Depends on bpa_pkg and buddy_page_allocator.
module buddy_page_allocator_tb
  import bpa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Top = 8;
  localparam int NPages = 256;
  localparam int NNodes = 511;
  localparam logic [3:0] NotAlloc = 4'd15;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] page;
    logic [3:0] order;
  } grant_t;

  typedef struct {
    logic        op;
    logic [20:0] bytes;
    logic [7:0]  pg;
    logic        typed;   // expected result given in the table
    grant_t      want;
  } req_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        opcode_i = OpAlloc;
  logic [20:0] request_bytes_i = '0;
  logic [7:0]  free_page_i = '0;
  logic        busy_o, done_o;
  logic [1:0]  status_o;
  logic [7:0]  granted_page_o;
  logic [3:0]  granted_order_o;

  buddy_page_allocator DUT (.*);

  always #4 clk_i = ~clk_i;

  // model state of the block tree
  bit         tree_free[NNodes];
  logic [3:0] blk_order[NPages];
  grant_t     grants_due[$];
  int         fails = 0;
  int         idle_cycles = 0;
  logic [7:0] live_pages[$];

  function automatic int node_idx(int page, int k);
    return ((1 << (Top - k)) - 1) + (page >> k);
  endfunction

  // compute the grant for one request and update the model tree
  function automatic grant_t predict_grant(logic op, logic [20:0] bytes, logic [7:0] pg);
    grant_t g;
    int need, k, page, orig, b;
    bit found;
    g = '0;
    need = 0; page = 0; found = 0;
    if (op == OpAlloc) begin
      if (bytes == 0 || bytes > 21'h100000) begin
        g.status = StBadSize;
        return g;
      end
      while (need < Top && (64'd1 << (12 + need)) < bytes) need++;
      for (k = need; k <= Top && !found; k++) begin
        for (int i = 0; i < (1 << (Top - k)); i++) begin
          if (tree_free[((1 << (Top - k)) - 1) + i]) begin
            page = i << k;
            found = 1;
            break;
          end
        end
        if (found) break;
      end
      if (!found) begin
        g.status = StNoMem;
        return g;
      end
      tree_free[node_idx(page, k)] = 0;
      while (k > need) begin
        k--;
        tree_free[node_idx(page + (1 << k), k)] = 1;
      end
      blk_order[page] = 4'(need);
      live_pages.push_back(8'(page));
      g.status = StOk; g.page = 8'(page); g.order = 4'(need);
    end else begin
      if (blk_order[pg] == NotAlloc || blk_order[pg] > Top) begin
        g.status = StBadFree;
        return g;
      end
      page = pg; k = blk_order[pg]; orig = k;
      blk_order[pg] = NotAlloc;
      foreach (live_pages[i]) if (live_pages[i] == pg) begin
        live_pages.delete(i);
        break;
      end
      while (k < Top) begin
        b = node_idx(page ^ (1 << k), k);
        if (!tree_free[b]) break;
        tree_free[b] = 0;
        page &= ~(1 << k);
        k++;
      end
      tree_free[node_idx(page, k)] = 1;
      g.status = StOk; g.order = 4'(orig);
    end
    return g;
  endfunction

  // drive one beat and wait for its acceptance
  task automatic send_req(req_row_t r);
    grant_t g;
    g = predict_grant(r.op, r.bytes, r.pg);
    if (r.typed && g != r.want) begin
      $error("table row disagrees: expected %h, model %h", r.want, g);
      fails++;
    end
    grants_due.push_back(g);
    start_i <= 1'b1;
    opcode_i <= r.op;
    request_bytes_i <= r.bytes;
    free_page_i <= r.pg;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle_gap(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    grant_t w;
    if (rst_ni && done_o) begin
      if (grants_due.size() == 0) begin
        $error("result with no request outstanding");
        fails++;
      end else begin
        w = grants_due.pop_front();
        if (status_o !== w.status) begin
          $error("status expected %0d actual %0d", w.status, status_o);
          fails++;
        end
        if (granted_page_o !== w.page) begin
          $error("granted_page expected %0d actual %0d", w.page, granted_page_o);
          fails++;
        end
        if (granted_order_o !== w.order) begin
          $error("granted_order expected %0d actual %0d", w.order, granted_order_o);
          fails++;
        end
      end
    end
  end

  // watchdog: cycles with no beat either way
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic req_row_t mk(logic op, logic [20:0] b, logic [7:0] p,
                                  logic t = 0, grant_t w = '0);
    req_row_t r;
    r.op = op; r.bytes = b; r.pg = p; r.typed = t; r.want = w;
    return r;
  endfunction

  initial begin
    req_row_t tbl[$];
    req_row_t r;
    int burst, sel;
    for (int i = 0; i < NNodes; i++) tree_free[i] = (i == 0);
    for (int i = 0; i < NPages; i++) blk_order[i] = NotAlloc;

    // directed rows
    tbl.push_back(mk(OpFree, 0, 0, 1, {StBadFree, 8'd0, 4'd0}));      // free before alloc
    tbl.push_back(mk(OpAlloc, 0, 0, 1, {StBadSize, 8'd0, 4'd0}));      // zero size
    tbl.push_back(mk(OpAlloc, 21'h100001, 0, 1, {StBadSize, 8'd0, 4'd0}));
    tbl.push_back(mk(OpAlloc, 21'h1FFFFF, 8'hFF, 1, {StBadSize, 8'd0, 4'd0}));
    tbl.push_back(mk(OpAlloc, 21'h100000, 0, 1, {StOk, 8'd0, 4'd8}));  // whole memory
    tbl.push_back(mk(OpAlloc, 1, 0, 1, {StNoMem, 8'd0, 4'd0}));        // memory full
    tbl.push_back(mk(OpFree, 0, 0, 1, {StOk, 8'd0, 4'd8}));
    tbl.push_back(mk(OpFree, 0, 0, 1, {StBadFree, 8'd0, 4'd0}));       // double free
    tbl.push_back(mk(OpAlloc, 1, 8'hFF, 1, {StOk, 8'd0, 4'd0}));       // one page, full split
    tbl.push_back(mk(OpAlloc, 4096, 0));
    tbl.push_back(mk(OpAlloc, 4097, 0));
    tbl.push_back(mk(OpAlloc, 21'h80000, 0));
    tbl.push_back(mk(OpAlloc, 21'h80000, 0));
    tbl.push_back(mk(OpFree, 0, 8'd3));                                // not a block start
    tbl.push_back(mk(OpFree, 0, 8'd255));
    tbl.push_back(mk(OpFree, 0, 8'd1));
    tbl.push_back(mk(OpFree, 21'h1FFFFF, 8'd2));
    tbl.push_back(mk(OpFree, 0, 8'd0));
    tbl.push_back(mk(OpFree, 0, 8'd128));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (tbl[i]) begin
      send_req(tbl[i]);
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 20));
    end

    // random traffic in bursts; mostly valid allocs and frees of live blocks
    for (int n = 0; n < 650;) begin
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst; j++, n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          r = mk(OpAlloc, (sel < 40) ? 21'($urandom_range(1, 1 << $urandom_range(12, 17)))
                                      : 21'($urandom_range(1, 21'h100000)), 8'($urandom));
        end else if (sel < 88 && live_pages.size() > 0) begin
          r = mk(OpFree, 21'($urandom),
                 live_pages[$urandom_range(0, live_pages.size() - 1)]);
        end else if (sel < 94) begin
          r = mk(OpFree, 21'($urandom), 8'($urandom));
        end else begin
          r = mk(OpAlloc, (sel < 97) ? 21'd0 : 21'($urandom_range(21'h100001, 21'h1FFFFF)),
                 8'($urandom));
        end
        send_req(r);
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 30));
    end
    start_i <= 1'b0;

    while (grants_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
